// File: hdl/lbce_pkg.sv
package lbce_pkg;

   localparam int KEY_BLOCK_W = 36;
   localparam int KEY_VER_W   = 31;
   localparam int DATA_W      = 64;
   localparam int COUNT_W     = 7;
   localparam int MAXB_W      = 7;
   localparam int DELB_W      = 6;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;

   localparam logic [MAXB_W-1:0] MAXB_RESET = 7'd64;
   localparam logic [DELB_W-1:0] DELB_RESET = 6'd8;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_BLOCKS    = 1'b0,
      CSR_DELETE_BLOCKS = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SEARCH,
      ST_TOUCH,
      ST_POPW,
      ST_AGE,
      ST_BATCH,
      ST_EVICT,
      ST_KILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]             cmd;
      logic [KEY_BLOCK_W-1:0] block_id;
      logic [KEY_VER_W-1:0]   version;
      logic [DATA_W-1:0]      data_in;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               stored;
      logic [DATA_W-1:0]  data_out;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // Key and payload of one cache line as held in the entry memory.
   typedef struct packed {
      logic [KEY_BLOCK_W-1:0] block_id;
      logic [KEY_VER_W-1:0]   version;
      logic [DATA_W-1:0]      data;
   } line_type;

endpackage

// File: hdl/lbce_entry_ram.sv
module lbce_entry_ram import lbce_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int AW = $clog2(CAPACITY)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_valid,
   input  logic [AW-1:0] wr_rank,
   input  line_type      wr_line,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_valid,
   output logic [AW-1:0] rd_rank,
   output line_type      rd_line
);

   logic          valid_mem [CAPACITY];
   logic [AW-1:0] rank_mem  [CAPACITY];
   line_type      line_mem  [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         valid_mem[wr_addr] <= wr_valid;
         rank_mem[wr_addr]  <= wr_rank;
         line_mem[wr_addr]  <= wr_line;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid <= valid_mem[rd_addr];
         rd_rank  <= rank_mem[rd_addr];
         rd_line  <= line_mem[rd_addr];
      end
   end

endmodule

// File: hdl/lbce_free_stack.sv
module lbce_free_stack import lbce_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int AW = $clog2(CAPACITY),
   parameter int PW = AW + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          push,
   input  logic [AW-1:0] push_slot,
   input  logic          pop,
   output logic [PW-1:0] depth,
   output logic [AW-1:0] top_slot
);

   logic [AW-1:0] stack_mem [CAPACITY];
   logic [PW-1:0] depth_ff;
   logic [PW-1:0] depth_in;
   logic [PW-1:0] top_idx;

   assign top_idx = depth_ff - PW'(1);
   assign depth   = depth_ff;

   always_comb begin
      depth_in = depth_ff;
      if (clear) begin
         depth_in = '0;
      end else if (push) begin
         depth_in = depth_ff + PW'(1);
      end else if (pop) begin
         depth_in = top_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[depth_ff[AW-1:0]] <= push_slot;
      end
      if (pop) begin
         top_slot <= stack_mem[top_idx[AW-1:0]];
      end
   end

endmodule

// File: hdl/lru_block_cache_batch_evict_core.sv
// A lookup is a search sweep over the entry memory, plus a recency sweep on a hit; an insert of
// a new key is a search sweep and an ageing sweep, with a free-stack pop between them when its
// slot comes from there. An insert that evicts adds an eviction sweep per extra entry in the batch.
// The block works one transaction at a time, each worked out by sweeps over the entry memory.
// A flush is a clearing pass over every entry. The receiver cannot stall: rsp_valid strobes for one cycle.
// Reset is synchronous: after it the block runs a clearing pass over every entry with busy high.
module lru_block_cache_batch_evict_core import lbce_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int PW   = AW + 1;
   localparam int CNTW = (PW > MAXB_W) ? PW : MAXB_W;

   // Every transaction is worked out by sweeps over the entry memory. A sweep issues one
   // read a cycle; the data comes back in the next cycle and is checked, and where an entry
   // changes it is written back at that same address. Addresses in one sweep are all
   // distinct, so a write never collides with a read of the same entry.
   // Recency is held as a rank per entry, 0 being most recent, and the valid entries
   // always carry the ranks 0 to count-1 exactly once.

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic          match_ff, match_in;
   logic [AW-1:0] mslot_ff, mslot_in;
   logic [AW-1:0] mrank_ff, mrank_in;
   logic          lru_found_ff, lru_found_in;
   logic [AW-1:0] lru_rank_ff, lru_rank_in;
   logic [AW-1:0] lru_slot_ff, lru_slot_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic          evict_ff, evict_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] held_ff, held_in;
   logic [PW-1:0] fresh_ff, fresh_in;
   logic          hit_ff, hit_in;
   logic          stored_ff, stored_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [MAXB_W-1:0] maxb_ff, maxb_in;
   logic [DELB_W-1:0] delb_ff, delb_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic          ram_wvalid;
   logic [AW-1:0] ram_wrank;
   line_type      ram_wline;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic          rd_valid;
   logic [AW-1:0] rd_rank;
   line_type      rd_line;

   logic          stk_clear;
   logic          stk_push;
   logic          stk_pop;
   logic [PW-1:0] stk_depth;
   logic [AW-1:0] stk_top;

   logic            issue;
   logic            sweep_done;
   logic            key_match;
   logic            lru_better;
   logic [CNTW-1:0] maxb_ext, delb_ext, eff_max, eff_del, held_ext;

   lbce_entry_ram #(.CAPACITY(CAPACITY), .AW(AW)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_valid(ram_wvalid),
      .wr_rank (ram_wrank),
      .wr_line (ram_wline),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_valid(rd_valid),
      .rd_rank (rd_rank),
      .rd_line (rd_line)
   );

   lbce_free_stack #(.CAPACITY(CAPACITY), .AW(AW), .PW(PW)) u_free_stack (
      .clock    (clock),
      .reset    (reset),
      .clear    (stk_clear),
      .push     (stk_push),
      .push_slot(lru_slot_ff),
      .pop      (stk_pop),
      .depth    (stk_depth),
      .top_slot (stk_top)
   );

   // The limit is clamped to 1..CAPACITY and the batch size to one below the limit.
   assign maxb_ext = CNTW'(maxb_ff);
   assign delb_ext = CNTW'(delb_ff);
   assign held_ext = CNTW'(held_ff);
   always_comb begin
      if (maxb_ext == '0) begin
         eff_max = CNTW'(1);
      end else if (maxb_ext > CNTW'(CAPACITY)) begin
         eff_max = CNTW'(CAPACITY);
      end else begin
         eff_max = maxb_ext;
      end
      eff_del = (delb_ext > eff_max - CNTW'(1)) ? eff_max - CNTW'(1) : delb_ext;
   end

   assign issue      = (ptr_ff != PW'(CAPACITY));
   assign sweep_done = !issue && !pend_ff;
   assign key_match  = rd_valid && (rd_line.block_id == req_ff.block_id)
                       && (rd_line.version == req_ff.version);
   assign lru_better = rd_valid && (!lru_found_ff || (rd_rank > lru_rank_ff));

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      match_in     = match_ff;
      mslot_in     = mslot_ff;
      mrank_in     = mrank_ff;
      lru_found_in = lru_found_ff;
      lru_rank_in  = lru_rank_ff;
      lru_slot_in  = lru_slot_ff;
      slot_in      = slot_ff;
      evict_in     = evict_ff;
      cnt_in       = cnt_ff;
      held_in      = held_ff;
      fresh_in     = fresh_ff;
      hit_in       = hit_ff;
      stored_in    = stored_ff;
      data_in      = data_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = pidx_ff;
      ram_wvalid   = 1'b0;
      ram_wrank    = '0;
      ram_wline    = rd_line;
      ram_re       = 1'b0;
      ram_raddr    = ptr_ff[AW-1:0];
      stk_clear    = 1'b0;
      stk_push     = 1'b0;
      stk_pop      = 1'b0;

      // Read side of a sweep, shared by every sweeping state.
      if ((state_ff == ST_SEARCH) || (state_ff == ST_TOUCH) || (state_ff == ST_AGE)
          || (state_ff == ST_EVICT)) begin
         ram_re  = issue;
         pend_in = issue;
         pidx_in = ptr_ff[AW-1:0];
         if (issue) begin
            ptr_in = ptr_ff + PW'(1);
         end
      end

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            // Clearing pass: mark every entry invalid, one a cycle.
            ram_we    = 1'b1;
            ram_waddr = ptr_ff[AW-1:0];
            if (ptr_ff == PW'(CAPACITY - 1)) begin
               ptr_in   = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end else begin
               ptr_in = ptr_ff + PW'(1);
            end
         end
         ST_IDLE: begin
            ptr_in = '0;
            if (start) begin
               req_in       = req_data;
               hit_in       = 1'b0;
               stored_in    = 1'b0;
               data_in      = '0;
               match_in     = 1'b0;
               lru_found_in = 1'b0;
               evict_in     = 1'b0;
               case (req_data.cmd)
                  CMD_LOOKUP, CMD_INSERT: begin
                     state_in = ST_SEARCH;
                  end
                  CMD_FLUSH: begin
                     stk_clear = 1'b1;
                     fresh_in  = '0;
                     held_in   = '0;
                     state_in  = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // Look for the key and note the least recent entry on the way.
            if (pend_ff) begin
               if (key_match) begin
                  match_in = 1'b1;
                  mslot_in = pidx_ff;
                  mrank_in = rd_rank;
                  data_in  = rd_line.data;
               end
               if (lru_better) begin
                  lru_found_in = 1'b1;
                  lru_rank_in  = rd_rank;
                  lru_slot_in  = pidx_ff;
               end
            end
            if (sweep_done) begin
               ptr_in = '0;
               if (match_ff) begin
                  hit_in   = 1'b1;
                  state_in = (req_ff.cmd == CMD_LOOKUP) ? ST_TOUCH : ST_DONE;
               end else if (req_ff.cmd == CMD_LOOKUP) begin
                  state_in = ST_DONE;
               end else begin
                  stored_in = 1'b1;
                  if ((held_ext < eff_max)
                      && ((stk_depth != '0) || (fresh_ff != PW'(CAPACITY)))) begin
                     if (stk_depth != '0) begin
                        stk_pop  = 1'b1;
                        state_in = ST_POPW;
                     end else begin
                        slot_in  = fresh_ff[AW-1:0];
                        fresh_in = fresh_ff + PW'(1);
                        held_in  = held_ff + PW'(1);
                        state_in = ST_AGE;
                     end
                  end else begin
                     // Full: the least recent entry gives up its slot.
                     slot_in  = lru_slot_ff;
                     evict_in = 1'b1;
                     state_in = ST_AGE;
                  end
               end
            end
         end
         ST_TOUCH: begin
            // Entries more recent than the hit one age by one; the hit one becomes newest.
            if (pend_ff) begin
               if (pidx_ff == mslot_ff) begin
                  ram_we     = 1'b1;
                  ram_wvalid = 1'b1;
                  ram_wrank  = '0;
               end else if (rd_valid && (rd_rank < mrank_ff)) begin
                  ram_we     = 1'b1;
                  ram_wvalid = 1'b1;
                  ram_wrank  = rd_rank + AW'(1);
               end
            end
            if (sweep_done) begin
               ptr_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_POPW: begin
            slot_in  = stk_top;
            held_in  = held_ff + PW'(1);
            state_in = ST_AGE;
         end
         ST_AGE: begin
            // Every valid entry ages by one and the new line lands as newest.
            if (pend_ff) begin
               if (pidx_ff == slot_ff) begin
                  ram_we             = 1'b1;
                  ram_wvalid         = 1'b1;
                  ram_wrank          = '0;
                  ram_wline.block_id = req_ff.block_id;
                  ram_wline.version  = req_ff.version;
                  ram_wline.data     = req_ff.data_in;
               end else if (rd_valid) begin
                  ram_we     = 1'b1;
                  ram_wvalid = 1'b1;
                  ram_wrank  = rd_rank + AW'(1);
               end
            end
            if (sweep_done) begin
               ptr_in = '0;
               if (evict_ff) begin
                  cnt_in   = eff_del;
                  state_in = ST_BATCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_BATCH: begin
            if ((cnt_ff != '0) && (held_ff > PW'(1))) begin
               lru_found_in = 1'b0;
               state_in     = ST_EVICT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EVICT: begin
            if (pend_ff && lru_better) begin
               lru_found_in = 1'b1;
               lru_rank_in  = rd_rank;
               lru_slot_in  = pidx_ff;
            end
            if (sweep_done) begin
               ptr_in   = '0;
               state_in = ST_KILL;
            end
         end
         ST_KILL: begin
            // Drop the least recent entry and hand its slot to the free stack.
            ram_we    = 1'b1;
            ram_waddr = lru_slot_ff;
            stk_push  = (stk_depth != PW'(CAPACITY));
            held_in   = held_ff - PW'(1);
            cnt_in    = cnt_ff - CNTW'(1);
            state_in  = ST_BATCH;
         end
         ST_DONE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.hit         = hit_ff;
            rsp_in.stored      = stored_ff;
            rsp_in.data_out    = data_ff;
            rsp_in.entry_count = held_ext[COUNT_W-1:0];
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      maxb_in = maxb_ff;
      delb_in = delb_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_BLOCKS:    maxb_in = csr_wdata[MAXB_W-1:0];
            CSR_DELETE_BLOCKS: delb_in = csr_wdata[DELB_W-1:0];
            default: begin
               maxb_in = maxb_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         held_ff      <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         maxb_ff      <= MAXB_RESET;
         delb_ff      <= DELB_RESET;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         held_ff      <= held_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         maxb_ff      <= maxb_in;
         delb_ff      <= delb_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pidx_ff      <= pidx_in;
      match_ff     <= match_in;
      mslot_ff     <= mslot_in;
      mrank_ff     <= mrank_in;
      lru_found_ff <= lru_found_in;
      lru_rank_ff  <= lru_rank_in;
      lru_slot_ff  <= lru_slot_in;
      slot_ff      <= slot_in;
      evict_ff     <= evict_in;
      cnt_ff       <= cnt_in;
      hit_ff       <= hit_in;
      stored_ff    <= stored_in;
      data_ff      <= data_in;
      rsp_ff       <= rsp_in;
   end

endmodule

// File: sim/lru_block_cache_batch_evict_core_test.sv
module lru_block_cache_batch_evict_core_test;
   import lbce_pkg::*;

   localparam int SLOTS = 64;
   // Command code that the block must treat as a no-op.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lru_block_cache_batch_evict_core #(.CAPACITY(SLOTS)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the cache contents, recency order and slot bookkeeping.
   logic [KEY_BLOCK_W-1:0] shadow_blk [SLOTS];
   logic [KEY_VER_W-1:0]   shadow_ver [SLOTS];
   logic [DATA_W-1:0]      shadow_word[SLOTS];
   bit                     shadow_valid[SLOTS];
   int                     shadow_rank[SLOTS];
   int                     free_slots[SLOTS];
   int                     free_top;
   int                     fresh_next;
   int                     held;
   int                     limit_reg;
   int                     batch_reg;

   rsp_type                pending_rsp[$];
   int                     fail_count;

   // Key pool for random traffic; small enough that hits and evictions are common.
   logic [KEY_BLOCK_W-1:0] pool_blk[96];
   logic [KEY_VER_W-1:0]   pool_ver[96];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs; far beyond the slowest legal run.
   initial begin
      #60000000;
      $display("lru_block_cache_batch_evict_core_test: FAIL");
      $finish;
   end

   function automatic int find_line(logic [KEY_BLOCK_W-1:0] b, logic [KEY_VER_W-1:0] v);
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_blk[i] == b && shadow_ver[i] == v)
            return i;
      return -1;
   endfunction

   function automatic int oldest_line();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && (best < 0 || shadow_rank[i] > shadow_rank[best]))
            best = i;
      return best;
   endfunction

   function automatic void fill_line(int s, req_type r);
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i])
            shadow_rank[i]++;
      shadow_blk[s]   = r.block_id;
      shadow_ver[s]   = r.version;
      shadow_word[s]  = r.data_in;
      shadow_rank[s]  = 0;
      shadow_valid[s] = 1'b1;
   endfunction

   // Computes the response of one transaction and advances the shadow cache.
   function automatic rsp_type cache_predict(req_type r);
      rsp_type res;
      int lim, batch, s, v, r0;
      res = '0;
      lim = (limit_reg < 1) ? 1 : (limit_reg > SLOTS) ? SLOTS : limit_reg;
      batch = (batch_reg > lim - 1) ? lim - 1 : batch_reg;
      case (r.cmd)
         CMD_LOOKUP: begin
            s = find_line(r.block_id, r.version);
            if (s >= 0) begin
               r0 = shadow_rank[s];
               for (int i = 0; i < SLOTS; i++)
                  if (shadow_valid[i] && shadow_rank[i] < r0)
                     shadow_rank[i]++;
               shadow_rank[s] = 0;
               res.hit = 1'b1;
               res.data_out = shadow_word[s];
            end
         end
         CMD_INSERT: begin
            s = find_line(r.block_id, r.version);
            if (s >= 0) begin
               res.hit = 1'b1;
               res.data_out = shadow_word[s];
            end else begin
               res.stored = 1'b1;
               if (held < lim && (free_top > 0 || fresh_next < SLOTS)) begin
                  if (free_top > 0) begin
                     free_top--;
                     s = free_slots[free_top];
                  end else begin
                     s = fresh_next;
                     fresh_next++;
                  end
                  fill_line(s, r);
                  held++;
               end else begin
                  // Full: the LRU line is replaced, then a batch of LRU lines is freed.
                  s = oldest_line();
                  if (s < 0) begin
                     s = 0;
                     held++;
                  end
                  fill_line(s, r);
                  for (int i = 0; i < batch && held > 1; i++) begin
                     v = oldest_line();
                     if (v < 0)
                        break;
                     shadow_valid[v] = 1'b0;
                     if (free_top < SLOTS) begin
                        free_slots[free_top] = v;
                        free_top++;
                     end
                     held--;
                  end
               end
            end
         end
         CMD_FLUSH: begin
            for (int i = 0; i < SLOTS; i++)
               shadow_valid[i] = 1'b0;
            free_top = 0;
            fresh_next = 0;
            held = 0;
         end
         default: ;
      endcase
      res.entry_count = held[COUNT_W-1:0];
      return res;
   endfunction

   // Every response must match the oldest outstanding prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: hit=%0d stored=%0d data_out=%h entry_count=%0d",
                   rsp_data.hit, rsp_data.stored, rsp_data.data_out, rsp_data.entry_count);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_data.hit);
               fail_count++;
            end
            if (rsp_data.stored !== want.stored) begin
               $error("stored: expected %0d, got %0d", want.stored, rsp_data.stored);
               fail_count++;
            end
            if (rsp_data.data_out !== want.data_out) begin
               $error("data_out: expected %h, got %h", want.data_out, rsp_data.data_out);
               fail_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want.entry_count, rsp_data.entry_count);
               fail_count++;
            end
         end
      end
   end

   // Issues one transaction after a random gap. start is left high on return so that
   // back-to-back transactions need no second assignment in the same time step.
   task automatic send_item(logic [1:0] cmd, logic [KEY_BLOCK_W-1:0] b,
                            logic [KEY_VER_W-1:0] v, logic [DATA_W-1:0] d);
      int gap;
      req_type r;
      rsp_type predicted;
      gap = $urandom_range(0, 3);
      r.cmd = cmd;
      r.block_id = b;
      r.version = v;
      r.data_in = d;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predicted = cache_predict(r);
      pending_rsp = {pending_rsp, predicted};
   endtask

   // Lowers start and waits for every response, plus a short settling margin.
   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_MAX_BLOCKS)
         limit_reg = value & 'h7f;
      else
         batch_reg = value & 'h3f;
   endtask

   function automatic logic [DATA_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Extremes of every field, each command, duplicates, misses and the unused code.
   task automatic test_directed();
      send_item(CMD_LOOKUP, '0, '0, '0);
      send_item(CMD_INSERT, '0, '0, '0);
      send_item(CMD_INSERT, '1, '1, '1);
      send_item(CMD_LOOKUP, '1, '1, '0);
      send_item(CMD_LOOKUP, '0, '0, '1);
      send_item(CMD_INSERT, '1, '1, 64'h0123_4567_89ab_cdef);
      send_item(CMD_LOOKUP, '1, '0, '0);
      send_item(CMD_LOOKUP, '0, '1, '0);
      send_item(CMD_INSERT, 36'h5_5555_5555, 31'h2aaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa);
      send_item(CMD_INSERT, 36'ha_aaaa_aaaa, 31'h5555_5555, 64'h5555_5555_5555_5555);
      send_item(CMD_LOOKUP, 36'h5_5555_5555, 31'h2aaa_aaaa, '0);
      send_item(CMD_UNUSED, '1, '1, '1);
      send_item(CMD_FLUSH, '1, '1, '1);
      send_item(CMD_LOOKUP, '0, '0, '0);
      send_item(CMD_INSERT, 36'd7, 31'd7, rand_word());
      drain();
   endtask

   // Limit of one with no batch, then the largest batch, so each insert replaces the last.
   task automatic test_tiny_limit();
      csr_write(CSR_MAX_BLOCKS, 1);
      csr_write(CSR_DELETE_BLOCKS, 0);
      for (int i = 0; i < 4; i++)
         send_item(CMD_INSERT, 36'(i), 31'(i), rand_word());
      send_item(CMD_LOOKUP, 36'd3, 31'd3, '0);
      send_item(CMD_LOOKUP, 36'd2, 31'd2, '0);
      drain();
      csr_write(CSR_DELETE_BLOCKS, 63);
      for (int i = 0; i < 3; i++)
         send_item(CMD_INSERT, 36'(i + 10), 31'(i), rand_word());
      drain();
      // A limit of zero is clamped to one.
      csr_write(CSR_MAX_BLOCKS, 0);
      for (int i = 0; i < 3; i++)
         send_item(CMD_INSERT, 36'(i + 20), 31'(i), rand_word());
      send_item(CMD_LOOKUP, 36'd22, 31'd2, '0);
      drain();
   endtask

   // Fill the whole cache, then drop the limit below the held count so that
   // each insert evicts and the batch drains the count down.
   task automatic test_limit_lowered();
      csr_write(CSR_MAX_BLOCKS, 127);
      csr_write(CSR_DELETE_BLOCKS, 0);
      send_item(CMD_FLUSH, '0, '0, '0);
      for (int i = 0; i < SLOTS + 2; i++)
         send_item(CMD_INSERT, 36'(i), 31'(i + 1), rand_word());
      send_item(CMD_LOOKUP, 36'd5, 31'd6, '0);
      drain();
      csr_write(CSR_MAX_BLOCKS, 4);
      csr_write(CSR_DELETE_BLOCKS, 2);
      for (int i = 0; i < 12; i++)
         send_item(CMD_INSERT, 36'(i + 100), 31'(i), rand_word());
      for (int i = 0; i < 12; i++)
         send_item(CMD_LOOKUP, 36'(i + 100), 31'(i), '0);
      drain();
   endtask

   // Random traffic over a small key pool under several register settings.
   task automatic test_random();
      int lim_set[8] = '{64, 5, 64, 16, 1, 127, 33, 8};
      int del_set[8] = '{8, 2, 63, 4, 0, 63, 1, 7};
      int k, pick;
      for (int i = 0; i < 96; i++) begin
         pool_blk[i] = KEY_BLOCK_W'({$urandom, $urandom});
         pool_ver[i] = KEY_VER_W'($urandom);
      end
      pool_blk[0] = '0;
      pool_ver[0] = '0;
      pool_blk[1] = '1;
      pool_ver[1] = '1;
      for (int p = 0; p < 8; p++) begin
         csr_write(CSR_MAX_BLOCKS, lim_set[p]);
         csr_write(CSR_DELETE_BLOCKS, del_set[p]);
         for (int n = 0; n < 120; n++) begin
            k = $urandom_range(0, 95);
            pick = $urandom_range(0, 99);
            if (pick < 48)
               send_item(CMD_INSERT, pool_blk[k], pool_ver[k], rand_word());
            else if (pick < 88)
               send_item(CMD_LOOKUP, pool_blk[k], pool_ver[k], rand_word());
            else if (pick < 93)
               send_item(CMD_LOOKUP, KEY_BLOCK_W'({$urandom, $urandom}),
                         KEY_VER_W'($urandom), rand_word());
            else if (pick < 96)
               send_item(CMD_UNUSED, KEY_BLOCK_W'({$urandom, $urandom}),
                         KEY_VER_W'($urandom), rand_word());
            else
               send_item(CMD_FLUSH, KEY_BLOCK_W'({$urandom, $urandom}),
                         KEY_VER_W'($urandom), rand_word());
         end
         drain();
      end
   endtask

   initial begin
      fail_count = 0;
      free_top = 0;
      fresh_next = 0;
      held = 0;
      limit_reg = 64;
      batch_reg = 8;
      for (int i = 0; i < SLOTS; i++)
         shadow_valid[i] = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_tiny_limit();
      test_limit_lowered();
      test_random();
      drain();
      if (fail_count == 0)
         $display("lru_block_cache_batch_evict_core_test: PASS");
      else
         $display("lru_block_cache_batch_evict_core_test: FAIL");
      $finish;
   end

endmodule
